[src/iqap_pkg.sv]
// Shared types and constants of the I/Q to amplitude and phase converter.
package iqap_pkg;

    localparam int GUARD_BITS = 8;
    localparam int HEAD_BITS  = 11;
    localparam int ANGLE_BITS = 32;
    localparam int AMP_BITS   = 16;
    localparam int PHASE_BITS = 16;
    localparam int GAIN_BITS  = 20;
    localparam int AMP_FRAC   = 4;
    localparam int ATAN_LEN   = 24;

    localparam logic [GAIN_BITS-1:0] GAIN_FIX = 20'd636751;
    localparam logic [ANGLE_BITS-1:0] ANGLE_PI = 32'h8000_0000;
    localparam logic [ANGLE_BITS-1:0] PHASE_ROUND = 32'h0000_8000;

    localparam logic [ANGLE_BITS-1:0] ATAN_TAB [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic valid;
        logic last;
        logic zero;
    } iqap_ctl_t;

endpackage

[src/iq_to_amplitude_phase.sv]
// Top level of the I/Q to amplitude and phase converter.
//
// The slave stream carries one word per converter sample pair: i_sample in the low
// SAMPLE_BITS of s_tdata, q_sample above it, zero padding up to whole bytes, and the
// record-end flag on s_tlast. Each word gives one result word on the master stream:
// amplitude (unsigned 12.4, saturating) in m_tdata[15:0] and phase (signed, pi/32768
// units) in m_tdata[31:16], with m_tlast copied from the input.
// The user writes the midscale offset through cfg_we and cfg_wdata only while the block
// is idle; the block does not enforce this. An accepted word passes the input register,
// one register per rotation stage, the gain multiplier and the output register.
// One word is accepted every clock while the receiver keeps up.
// When m_tready is low, one finished word waits in the output register and one more is
// caught in a skid register; only then does s_tready fall and the whole chain hold.
// Reset empties the chain, the output and skid registers, and sets midscale to
// 2^(SAMPLE_BITS-1) - 1.
module iq_to_amplitude_phase
    import iqap_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // i_sample, q_sample, zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // amplitude, phase
    output logic [AMP_BITS+PHASE_BITS-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [SAMPLE_BITS-1:0]         cfg_wdata
);

    localparam int W = SAMPLE_BITS + HEAD_BITS;
    localparam int OUT_W = AMP_BITS + PHASE_BITS;
    localparam logic [SAMPLE_BITS-1:0] MID_RESET = (SAMPLE_BITS)'((1 << (SAMPLE_BITS - 1)) - 1);

    logic [SAMPLE_BITS-1:0] midscale_reg;
    logic                   en;

    iqap_ctl_t             ctl_pipe [CORDIC_STAGES+1];
    logic signed [W-1:0]   x_pipe [CORDIC_STAGES+1];
    logic signed [W-1:0]   y_pipe [CORDIC_STAGES+1];
    logic [ANGLE_BITS-1:0] z_pipe [CORDIC_STAGES+1];

    iqap_ctl_t             post_ctl;
    logic [AMP_BITS-1:0]   post_amp;
    logic [PHASE_BITS-1:0] post_phase;

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;
    logic                  out_last_reg;
    logic                  skid_valid_reg;
    logic [OUT_W-1:0]      skid_data_reg;
    logic                  skid_last_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midscale_reg <= MID_RESET;
        end
        else if (cfg_we)
        begin
            midscale_reg <= cfg_wdata;
        end
    end

    iqap_pre #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .W           (W)
    ) u_pre (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid_in (s_tvalid),
        .last_in  (s_tlast),
        .i_sample (s_tdata[SAMPLE_BITS-1:0]),
        .q_sample (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .midscale (midscale_reg),
        .ctl_out  (ctl_pipe[0]),
        .x_out    (x_pipe[0]),
        .y_out    (y_pipe[0]),
        .z_out    (z_pipe[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        iqap_cell #(
            .W     (W),
            .STAGE (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_pipe[g]),
            .x_in    (x_pipe[g]),
            .y_in    (y_pipe[g]),
            .z_in    (z_pipe[g]),
            .ctl_out (ctl_pipe[g+1]),
            .x_out   (x_pipe[g+1]),
            .y_out   (y_pipe[g+1]),
            .z_out   (z_pipe[g+1])
        );
    end

    iqap_post #(
        .W (W)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (ctl_pipe[CORDIC_STAGES]),
        .x_in      (x_pipe[CORDIC_STAGES]),
        .z_in      (z_pipe[CORDIC_STAGES]),
        .ctl_out   (post_ctl),
        .amplitude (post_amp),
        .phase     (post_phase)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= post_ctl.valid;
            end
        end
        else if (post_ctl.valid && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end
            else
            begin
                out_data_reg <= {post_phase, post_amp};
                out_last_reg <= post_ctl.last;
            end
        end
        else if (post_ctl.valid && en)
        begin
            skid_data_reg <= {post_phase, post_amp};
            skid_last_reg <= post_ctl.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && post_ctl.valid && en) |=> skid_valid_reg)
        else $error("finished word was dropped while the receiver stalled");

    a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid register filled without a stall");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_tready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid word was not moved to the output");
`endif

endmodule

[src/iqap_pre.sv]
// Input cell: removes the midscale offset and folds the vector into the right half plane.
module iqap_pre
    import iqap_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int W           = 23
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_in,
    input  logic                   last_in,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] q_sample,
    input  logic [SAMPLE_BITS-1:0] midscale,
    output iqap_ctl_t              ctl_out,
    output logic signed [W-1:0]    x_out,
    output logic signed [W-1:0]    y_out,
    output logic [ANGLE_BITS-1:0]  z_out
);

    logic signed [SAMPLE_BITS:0] ic;
    logic signed [SAMPLE_BITS:0] qc;
    logic signed [W-1:0]         ie;
    logic signed [W-1:0]         qe;
    logic signed [W-1:0]         xs;
    logic signed [W-1:0]         ys;
    iqap_ctl_t                   ctl_reg;
    iqap_ctl_t                   ctl_next;
    logic signed [W-1:0]         x_reg;
    logic signed [W-1:0]         x_next;
    logic signed [W-1:0]         y_reg;
    logic signed [W-1:0]         y_next;
    logic [ANGLE_BITS-1:0]       z_reg;
    logic [ANGLE_BITS-1:0]       z_next;

    always_comb
    begin
        ic = $signed({1'b0, i_sample}) - $signed({1'b0, midscale});
        qc = $signed({1'b0, q_sample}) - $signed({1'b0, midscale});
        ie = {{(W-SAMPLE_BITS-1){ic[SAMPLE_BITS]}}, ic};
        qe = {{(W-SAMPLE_BITS-1){qc[SAMPLE_BITS]}}, qc};
        xs = qe <<< GUARD_BITS;
        ys = ie <<< GUARD_BITS;
        ctl_next.valid = valid_in;
        ctl_next.last  = last_in;
        ctl_next.zero  = (ic == '0) && (qc == '0);
        if (qc[SAMPLE_BITS])
        begin
            x_next = -xs;
            y_next = -ys;
            z_next = ANGLE_PI;
        end
        else
        begin
            x_next = xs;
            y_next = ys;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

[src/iqap_cell.sv]
// One vectoring rotation stage of the shift-add chain.
module iqap_cell
    import iqap_pkg::*;
#(
    parameter int W     = 23,
    parameter int STAGE = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  iqap_ctl_t             ctl_in,
    input  logic signed [W-1:0]   x_in,
    input  logic signed [W-1:0]   y_in,
    input  logic [ANGLE_BITS-1:0] z_in,
    output iqap_ctl_t             ctl_out,
    output logic signed [W-1:0]   x_out,
    output logic signed [W-1:0]   y_out,
    output logic [ANGLE_BITS-1:0] z_out
);

    localparam logic [ANGLE_BITS-1:0] STEP = ATAN_TAB[STAGE];

    logic signed [W-1:0]   xs;
    logic signed [W-1:0]   ys;
    iqap_ctl_t             ctl_reg;
    logic signed [W-1:0]   x_reg;
    logic signed [W-1:0]   x_next;
    logic signed [W-1:0]   y_reg;
    logic signed [W-1:0]   y_next;
    logic [ANGLE_BITS-1:0] z_reg;
    logic [ANGLE_BITS-1:0] z_next;

    always_comb
    begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        if (!y_in[W-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + STEP;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

[src/iqap_post.sv]
// Output cell: gain correction, rounding and saturation of the magnitude, rounding of the angle.
module iqap_post
    import iqap_pkg::*;
#(
    parameter int W = 23
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  iqap_ctl_t             ctl_in,
    input  logic signed [W-1:0]   x_in,
    input  logic [ANGLE_BITS-1:0] z_in,
    output iqap_ctl_t             ctl_out,
    output logic [AMP_BITS-1:0]   amplitude,
    output logic [PHASE_BITS-1:0] phase
);

    localparam int PW = W - 1 + GAIN_BITS;
    localparam int RS = GAIN_BITS + GUARD_BITS - AMP_FRAC;
    localparam int AW = PW + 1 - RS;
    localparam int EW = AW + AMP_BITS + 1;
    localparam logic [PW:0] ROUND_ADD = (PW + 1)'(1) << (RS - 1);
    localparam logic [EW-1:0] AMP_MAX = EW'({AMP_BITS{1'b1}});

    iqap_ctl_t             ctl_reg;
    logic [PW-1:0]         prod_reg;
    logic [PW-1:0]         prod_next;
    logic [ANGLE_BITS-1:0] z_reg;
    logic [PW:0]           sum;
    logic [AW-1:0]         amp_wide;
    logic [EW-1:0]         amp_ext;
    logic [ANGLE_BITS-1:0] z_round;

    assign prod_next = PW'(x_in[W-2:0]) * PW'(GAIN_FIX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            z_reg    <= z_in;
        end
    end

    always_comb
    begin
        sum      = {1'b0, prod_reg} + ROUND_ADD;
        amp_wide = sum[PW:RS];
        amp_ext  = EW'(amp_wide);
        z_round  = z_reg + PHASE_ROUND;
        if (ctl_reg.zero)
        begin
            amplitude = '0;
            phase     = '0;
        end
        else
        begin
            amplitude = (amp_ext > AMP_MAX) ? {AMP_BITS{1'b1}} : amp_ext[AMP_BITS-1:0];
            phase     = z_round[ANGLE_BITS-1 -: PHASE_BITS];
        end
    end

    assign ctl_out = ctl_reg;

endmodule
